FILE: design/stripe_pattern_pixel_generator_macros.svh
// assertion macros for the stripe pattern pixel generator
// included by the modules that carry concurrent checks; no other dependencies
`ifndef STRIPE_PATTERN_PIXEL_GENERATOR_MACROS_SVH
`define STRIPE_PATTERN_PIXEL_GENERATOR_MACROS_SVH

// condition implies consequence in the same cycle, checked outside reset
`define SPG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds, checked outside reset
`define SPG_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

FILE: design/spg_pkg.sv
// shared types and constants of the stripe pattern pixel generator
// no dependencies; imported by spg_div_stage, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

  // parameter defaults
  localparam int unsigned PATTERN_COUNT_DEF = 8;
  localparam int unsigned RASTER_ROWS_DEF   = 1024;
  localparam int unsigned RASTER_COLS_DEF   = 1024;

  // field widths
  localparam int unsigned FRAME_W = 5;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned GREY_W  = 8;
  localparam int unsigned REM_W   = LEN_W;
  // pattern index comes from the upper frame bits
  localparam int unsigned K_W     = FRAME_W - 1;
  localparam int unsigned STEP_W  = K_W + 1;
  localparam int unsigned DIM_W   = 13;

  localparam logic [GREY_W-1:0] GREY_WHITE = '1;
  localparam logic [GREY_W-1:0] GREY_BLACK = '0;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_FIRST_ROW = 3'd0,
    REG_PATTERN_FIRST_COL = 3'd1,
    REG_PATTERN_HEIGHT    = 3'd2,
    REG_PATTERN_WIDTH     = 3'd3,
    REG_MARK_FIRST_ROW    = 3'd4,
    REG_MARK_FIRST_COL    = 3'd5,
    REG_MARK_HEIGHT       = 3'd6,
    REG_MARK_WIDTH        = 3'd7
  } spg_reg_e;

  // per-pixel control carried alongside the remainder
  typedef struct packed {
    logic           oor;     // frame number past the last frame
    logic           white;   // frame 0 inside the image
    logic           active;  // stripe pixel, value from the quotient bits
    logic           neg;     // inverted frame of the pair
    logic [K_W-1:0] k;       // pattern index
    logic           stripe;  // xor of quotient bits k and k+1 so far
  } spg_side_t;

endpackage

`default_nettype wire

FILE: design/spg_div_stage.sv
// one restoring division step of y / pattern_height with its pipeline register
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_div_stage import spg_pkg::*; #(
  parameter int unsigned STEP = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire spg_side_t        side_i,
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic [LEN_W-1:0] height_i,
  output logic                  valid_o,
  output spg_side_t             side_o,
  output logic [REM_W-1:0]      rem_o
);

  logic [REM_W:0]   dbl;
  logic [REM_W:0]   diff;
  logic             qbit;
  logic             tap;
  logic [REM_W-1:0] rem_d;
  spg_side_t        side_d;
  logic             valid_q;
  spg_side_t        side_q;
  logic [REM_W-1:0] rem_q;

  // shift in a zero and try to subtract the divisor
  assign dbl   = {rem_i, 1'b0};
  assign diff  = dbl - {1'b0, height_i};
  assign qbit  = dbl >= {1'b0, height_i};
  assign rem_d = qbit ? diff[REM_W-1:0] : dbl[REM_W-1:0];

  // this quotient bit counts when it is bit k or bit k+1
  assign tap = (STEP_W'(side_i.k) == STEP_W'(STEP)) ||
               ((STEP_W'(side_i.k) + STEP_W'(1)) == STEP_W'(STEP));

  always_comb begin
    side_d        = side_i;
    side_d.stripe = side_i.stripe ^ (tap & qbit);
  end

  // valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire

FILE: design/stripe_pattern_pixel_generator.sv
// Stripe pattern pixel generator: one pixel per clock when there is no backpressure. The stripe
// bit is bit k xor bit k+1 of the binary fraction of y / pattern_height, produced by a chain of
// PATTERN_COUNT + 1 restoring division stages, one quotient bit per stage, after a front
// stage that decodes the frame and tests the rectangles, and before an output register.
// Empty stages collapse under backpressure, so input is taken while results wait. The user
// must keep the configuration static while pixels are in flight; the block does not enforce
// it. Depends on spg_pkg, spg_div_stage and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "stripe_pattern_pixel_generator_macros.svh"

module stripe_pattern_pixel_generator import spg_pkg::*; #(
  parameter int unsigned PATTERN_COUNT = PATTERN_COUNT_DEF,
  parameter int unsigned RASTER_ROWS   = RASTER_ROWS_DEF,
  parameter int unsigned RASTER_COLS   = RASTER_COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [LEN_W-1:0]  cfg_data_i,
  // pixel requests
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [31:0]       s_tdata,   // frame_number[4:0], pixel_row[14:5],
                                            // pixel_col[24:15], zero fill
  // pixel values
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [GREY_W-1:0]      m_tdata,   // grey_value[7:0]
  output logic                   m_tuser    // frame_out_of_range[0]
);

  localparam int unsigned DIV_STAGES = PATTERN_COUNT + 1;
  localparam int unsigned LAST       = DIV_STAGES + 1;
  localparam logic [FRAME_W:0] FrameLast = (FRAME_W + 1)'(2 * PATTERN_COUNT);

  // configuration registers
  logic [COORD_W-1:0] pat_row_q, pat_col_q, mark_row_q, mark_col_q;
  logic [LEN_W-1:0]   pat_height_q, pat_width_q, mark_height_q, mark_width_q;

  // pipeline control
  logic [LAST:0] vld;
  logic [LAST:0] en;

  spg_side_t        side [0:DIV_STAGES];
  logic [REM_W-1:0] rem  [0:DIV_STAGES];

  // front stage
  logic [FRAME_W-1:0] frame;
  logic [COORD_W-1:0] row, col;
  logic [FRAME_W-1:0] frame_m1;
  logic               oor_c, in_image_c, in_pattern_c, in_mark_c, frame_zero_c;
  logic [COORD_W-1:0] y_c;
  spg_side_t          side_c;
  logic               vld0_q;
  spg_side_t          side0_q;
  logic [REM_W-1:0]   rem0_q;

  // output stage
  logic [GREY_W-1:0] grey_d;
  logic              out_vld_q;
  logic [GREY_W-1:0] grey_q;
  logic              oor_q;

  function automatic logic in_span(logic [COORD_W-1:0] v, logic [COORD_W-1:0] first,
                                   logic [LEN_W-1:0] len);
    logic [LEN_W:0] lim;
    lim = (LEN_W + 1)'(first) + (LEN_W + 1)'(len);
    return (v >= first) && ((LEN_W + 1)'(v) < lim);
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_row_q     <= '0;
      pat_col_q     <= '0;
      pat_height_q  <= LEN_W'(1024);
      pat_width_q   <= LEN_W'(1024);
      mark_row_q    <= '0;
      mark_col_q    <= '0;
      mark_height_q <= '0;
      mark_width_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (spg_reg_e'(cfg_index_i))
        REG_PATTERN_FIRST_ROW: pat_row_q     <= cfg_data_i[COORD_W-1:0];
        REG_PATTERN_FIRST_COL: pat_col_q     <= cfg_data_i[COORD_W-1:0];
        REG_PATTERN_HEIGHT:    pat_height_q  <= cfg_data_i;
        REG_PATTERN_WIDTH:     pat_width_q   <= cfg_data_i;
        REG_MARK_FIRST_ROW:    mark_row_q    <= cfg_data_i[COORD_W-1:0];
        REG_MARK_FIRST_COL:    mark_col_q    <= cfg_data_i[COORD_W-1:0];
        REG_MARK_HEIGHT:       mark_height_q <= cfg_data_i;
        REG_MARK_WIDTH:        mark_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  assign en[LAST] = !vld[LAST] || m_tready;
  for (genvar i = 0; i < LAST; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign s_tready = en[0];

  // request decode
  assign frame    = s_tdata[4:0];
  assign row      = s_tdata[14:5];
  assign col      = s_tdata[24:15];
  assign frame_m1 = frame - FRAME_W'(1);

  assign oor_c        = {1'b0, frame} > FrameLast;
  assign frame_zero_c = frame == '0;
  assign in_image_c   = (DIM_W'(row) < DIM_W'(RASTER_ROWS)) &&
                        (DIM_W'(col) < DIM_W'(RASTER_COLS));
  assign in_pattern_c = (pat_height_q != '0) &&
                        in_span(row, pat_row_q, pat_height_q) &&
                        in_span(col, pat_col_q, pat_width_q);
  assign in_mark_c    = (mark_height_q != '0) &&
                        in_span(row, mark_row_q, mark_height_q) &&
                        in_span(col, mark_col_q, mark_width_q);
  assign y_c          = row - pat_row_q;

  always_comb begin
    side_c.oor    = oor_c;
    side_c.white  = !oor_c && in_image_c && frame_zero_c;
    side_c.active = !oor_c && in_image_c && !frame_zero_c && in_pattern_c && !in_mark_c;
    side_c.neg    = frame_m1[0];
    side_c.k      = frame_m1[FRAME_W-1:1];
    side_c.stripe = 1'b0;
  end

  // front stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en[0]) begin
      vld0_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side0_q <= side_c;
      rem0_q  <= REM_W'(y_c);
    end
  end

  assign vld[0]  = vld0_q;
  assign side[0] = side0_q;
  assign rem[0]  = rem0_q;

  // division chain, one fraction bit of y / height per stage
  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
    spg_div_stage #(
      .STEP(i)
    ) u_div_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en[i]),
      .valid_i  (vld[i-1]),
      .side_i   (side[i-1]),
      .rem_i    (rem[i-1]),
      .height_i (pat_height_q),
      .valid_o  (vld[i]),
      .side_o   (side[i]),
      .rem_o    (rem[i])
    );
  end

  // pixel value
  always_comb begin
    priority if (side[DIV_STAGES].white) begin
      grey_d = GREY_WHITE;
    end else if (side[DIV_STAGES].active &&
                 (side[DIV_STAGES].stripe ^ side[DIV_STAGES].neg)) begin
      grey_d = GREY_WHITE;
    end else begin
      grey_d = GREY_BLACK;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[LAST]) begin
      out_vld_q <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      grey_q <= grey_d;
      oor_q  <= side[DIV_STAGES].oor;
    end
  end

  assign vld[LAST] = out_vld_q;
  assign m_tvalid  = out_vld_q;
  assign m_tdata   = grey_q;
  assign m_tuser   = oor_q;

  // checks
  `SPG_ASSERT_IMP(a_grey_binary, clk_i, rst_ni, m_tvalid && (m_tdata != GREY_BLACK),
                  m_tdata == GREY_WHITE, "grey value neither black nor white")
  `SPG_ASSERT_IMP(a_oor_black, clk_i, rst_ni, m_tvalid && m_tuser,
                  m_tdata == GREY_BLACK, "out of range frame gives a lit pixel")
  `SPG_ASSERT_IMP(a_stall_source, clk_i, rst_ni, !s_tready,
                  m_tvalid && !m_tready, "input stalled without output backpressure")
  `SPG_ASSERT_NEVER(a_front_exclusive, clk_i, rst_ni,
                    vld0_q && side0_q.white && side0_q.active,
                    "pixel marked both white frame and stripe")

endmodule

`default_nettype wire

FILE: sim/stripe_pattern_pixel_generator_tb.sv
// Self-checking testbench of the stripe pattern pixel generator: predicts every pixel value
// from its own copy of the configuration and checks each output transfer in order.
// Depends on spg_pkg and the stripe_pattern_pixel_generator top level.
`timescale 1ns / 1ps

module stripe_pattern_pixel_generator_tb;
  import spg_pkg::*;

  localparam int unsigned PATTERNS    = PATTERN_COUNT_DEF;
  localparam int unsigned DUT_LATENCY = PATTERN_COUNT_DEF + 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTINGS_N  = 10;
  localparam int unsigned RANDOM_N    = 125;
  localparam int unsigned HOLD_AT     = 330;
  localparam int unsigned HOLD_CYCLES = 120;

  // one pixel request, frame in the lowest bits as on s_tdata
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [FRAME_W-1:0] frame;
  } pixel_req_t;

  typedef struct packed {
    logic              oor;
    logic [GREY_W-1:0] grey;
  } pixel_value_t;

  localparam int unsigned REQ_W = $bits(pixel_req_t);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_index_i = '0;
  logic [LEN_W-1:0]  cfg_data_i = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;    // frame_number[4:0], pixel_row[14:5], pixel_col[24:15]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [GREY_W-1:0] m_tdata;         // grey_value[7:0]
  logic              m_tuser;         // frame_out_of_range[0]

  // configuration copy, reset values of the block
  int unsigned pat_row  = 0;
  int unsigned pat_col  = 0;
  int unsigned pat_h    = 1024;
  int unsigned pat_w    = 1024;
  int unsigned mark_row = 0;
  int unsigned mark_col = 0;
  int unsigned mark_h   = 0;
  int unsigned mark_w   = 0;

  pixel_req_t   pixel_requests[$];
  pixel_value_t pending_values[$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  int unsigned  tx_gap = 0;
  int unsigned  rx_stall = 0;

  stripe_pattern_pixel_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit in_span(int unsigned v, int unsigned first, int unsigned len);
    return v >= first && v < first + len;
  endfunction

  // grey value of one pixel under the current configuration
  function automatic pixel_value_t stripe_pixel_value(pixel_req_t p);
    pixel_value_t    v;
    int unsigned     k;
    bit              negative;
    bit              in_pattern;
    bit              in_mark;
    bit              stripe;
    longint unsigned y;
    longint unsigned q;
    v.grey = GREY_BLACK;
    v.oor  = 1'b0;
    if (p.frame > 2 * PATTERNS) begin
      v.oor = 1'b1;
    end else if (p.row >= RASTER_ROWS_DEF || p.col >= RASTER_COLS_DEF) begin
      v.grey = GREY_BLACK;
    end else if (p.frame == 0) begin
      v.grey = GREY_WHITE;
    end else begin
      k          = (p.frame - 1) >> 1;
      negative   = (p.frame - 1) & 1;
      in_pattern = pat_h != 0 && in_span(p.row, pat_row, pat_h) && in_span(p.col, pat_col, pat_w);
      in_mark    = mark_h != 0 && in_span(p.row, mark_row, mark_h) &&
                   in_span(p.col, mark_col, mark_w);
      if (in_pattern && !in_mark) begin
        // round half up of y * 2^k / R, kept exact in integers
        y      = p.row - pat_row;
        q      = ((y << (k + 1)) + pat_h) / (2 * pat_h);
        stripe = q[0] ^ negative;
        v.grey = stripe ? GREY_WHITE : GREY_BLACK;
      end
    end
    return v;
  endfunction

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, 9) : 0;
  endfunction

  // coordinate aimed at the pattern, the mark, their borders or anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned first, int unsigned len,
                                                    int unsigned mfirst, int unsigned mlen);
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(0, 9);
    if (sel < 5 && len != 0)       v = first + $urandom_range(0, len - 1);
    else if (sel < 7 && mlen != 0) v = mfirst + $urandom_range(0, mlen - 1);
    else if (sel == 7)             v = first + len;
    else if (sel == 8 && first != 0) v = first - 1;
    else                           v = $urandom_range(0, 1023);
    if (v > 1023) v = 1023;
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    p.frame = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    p.row   = pick_coord(pat_row, pat_h, mark_row, mark_h);
    p.col   = pick_coord(pat_col, pat_w, mark_col, mark_w);
    return p;
  endfunction

  function automatic pixel_req_t make_pixel(int unsigned frame, int unsigned row,
                                            int unsigned col);
    pixel_req_t p;
    p.frame = frame;
    p.row   = row;
    p.col   = col;
    return p;
  endfunction

  // register write, copy updated at the same edge
  task automatic write_reg(spg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PATTERN_FIRST_ROW: pat_row  = val & 32'h3FF;
      REG_PATTERN_FIRST_COL: pat_col  = val & 32'h3FF;
      REG_PATTERN_HEIGHT:    pat_h    = val & 32'h7FF;
      REG_PATTERN_WIDTH:     pat_w    = val & 32'h7FF;
      REG_MARK_FIRST_ROW:    mark_row = val & 32'h3FF;
      REG_MARK_FIRST_COL:    mark_col = val & 32'h3FF;
      REG_MARK_HEIGHT:       mark_h   = val & 32'h7FF;
      default:               mark_w   = val & 32'h7FF;
    endcase
  endtask

  task automatic write_setting(int unsigned pr, int unsigned pc, int unsigned ph,
                               int unsigned pw, int unsigned mr, int unsigned mc,
                               int unsigned mh, int unsigned mw);
    write_reg(REG_PATTERN_FIRST_ROW, pr);
    write_reg(REG_PATTERN_FIRST_COL, pc);
    write_reg(REG_PATTERN_HEIGHT, ph);
    write_reg(REG_PATTERN_WIDTH, pw);
    write_reg(REG_MARK_FIRST_ROW, mr);
    write_reg(REG_MARK_FIRST_COL, mc);
    write_reg(REG_MARK_HEIGHT, mh);
    write_reg(REG_MARK_WIDTH, mw);
  endtask

  // block is idle once every request is sent and every value has come back
  task automatic wait_idle();
    while (pixel_requests.size() != 0 || s_tvalid || pending_values.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int unsigned random_len(int unsigned lo);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(lo, 1024) : $urandom_range(lo, 16);
  endfunction

  // request driver: one transfer per item, random gap after each when gaps are switched on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        pending_values.insert(pending_values.size(),
                              stripe_pixel_value(pixel_req_t'(s_tdata[REQ_W-1:0])));
        tx_gap = draw_wait(tx_idle_on);
      end
      if (tx_gap != 0) begin
        s_tvalid <= 1'b0;
        tx_gap = tx_gap - 1;
      end else if (pixel_requests.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {{(32 - REQ_W){1'b0}}, pixel_requests.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, while requests keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // value monitor: compare against the oldest prediction, random stall after each when stalls are on
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_value_t exp_v;
    int unsigned  stall;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      stall = 0;
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        stall = draw_wait(rx_idle_on);
        if (pending_values.size() == 0) begin
          $display("%0t: value with nothing pending: grey %0d oor %0b", $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          exp_v = pending_values.pop_front();
          if (m_tdata !== exp_v.grey) begin
            $display("%0t: grey_value expected %0d actual %0d", $time, exp_v.grey, m_tdata);
            mismatch_count++;
          end
          if (m_tuser !== exp_v.oor) begin
            $display("%0t: frame_out_of_range expected %0b actual %0b", $time, exp_v.oor,
                     m_tuser);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (stall != 0) begin
        m_tready <= 1'b0;
        rx_stall = stall - 1;
      end else if (rx_stall != 0) begin
        m_tready <= 1'b0;
        rx_stall = rx_stall - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus: one batch of requests per configuration setting
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < SETTINGS_N; ph++) begin
      if (ph != 0) wait_idle();
      case (ph)
        0: ;  // reset configuration
        1: write_setting(0, 0, 1, 1, 1023, 1023, 1024, 1024);
        2: write_setting(0, 0, 0, 1024, 0, 0, 0, 1024);
        3: write_setting(100, 200, 3, 1024, 101, 0, 1, 0);
        4: write_setting(0, 0, 1024, 1024, 256, 256, 512, 512);
        5: write_setting(1023, 0, 1024, 1024, 0, 1023, 1024, 1);
        default: write_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                               random_len(1), random_len(1),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               random_len(0), random_len(0));
      endcase
      tx_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
      rx_idle_on = (ph % 4 == 0) || (ph % 4 == 3);
      if (ph == 0) begin
        // every frame of the set, the frames past it and the image corners
        for (int f = 0; f <= 2 * PATTERNS; f++)
          pixel_requests.insert(pixel_requests.size(), make_pixel(f, (f * 61) % 1024, f * 37));
        pixel_requests.insert(pixel_requests.size(), make_pixel(17, 0, 0));
        pixel_requests.insert(pixel_requests.size(), make_pixel(31, 1023, 1023));
        pixel_requests.insert(pixel_requests.size(), make_pixel(1, 1023, 1023));
        pixel_requests.insert(pixel_requests.size(), make_pixel(16, 1023, 0));
        pixel_requests.insert(pixel_requests.size(), make_pixel(2, 0, 1023));
        pixel_requests.insert(pixel_requests.size(), make_pixel(0, 1023, 1023));
      end
      for (int n = 0; n < RANDOM_N; n++)
        pixel_requests.insert(pixel_requests.size(), random_pixel());
    end
    wait_idle();
    repeat (4 * DUT_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
